// File: hdl/lpast_pkg.sv
// lpast_pkg: shared types and codes for the linear probe address/size table
// holds command and status codes, hash constants and fixed port widths
// no dependencies
`timescale 1ns / 1ps

package lpast_pkg;

   // fixed widths of the transaction fields
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 32;
   localparam int OCC_W    = 12;
   localparam int HASH_W   = 32;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [FOUND_W-1:0]  found_type;
   typedef logic [OCC_W-1:0]    occ_type;

   // command codes
   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_REMOVE = 2'd1;
   localparam cmd_type CMD_SEARCH = 2'd2;
   localparam cmd_type CMD_UNDEF  = 2'd3;

   // status codes
   localparam status_type STATUS_OK   = 2'd0;
   localparam status_type STATUS_DUP  = 2'd1;
   localparam status_type STATUS_MISS = 2'd2;
   localparam status_type STATUS_FULL = 2'd3;

   // home slot offset: multiplier times seed, added with wrap
   localparam int HASH_MUL  = 37;
   localparam int HASH_SEED = 10;
   localparam logic [HASH_W-1:0] HASH_OFFSET = HASH_W'(HASH_MUL * HASH_SEED);

endpackage

// File: hdl/lpast_hash.sv
// lpast_hash: home slot unit, offset, magnitude and reduction modulo the capacity
// a power-of-two capacity reduces by mask, others by reciprocal multiply
// depends on lpast_pkg
`timescale 1ns / 1ps

module lpast_hash #(
   parameter int CAPACITY = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lpast_pkg::HASH_W-1:0]      key_low,
   output logic                              done,
   output logic [$clog2(CAPACITY)-1:0]       home
);
   import lpast_pkg::*;

   localparam int  IDX_W    = $clog2(CAPACITY);
   localparam bit  IS_POW2  = (CAPACITY & (CAPACITY - 1)) == 0;

   logic [HASH_W-1:0] sum;
   logic [HASH_W-1:0] mag;

   // offset with wrap, then unsigned magnitude of the signed sum
   assign sum = key_low + HASH_OFFSET;
   assign mag = sum[HASH_W-1] ? (HASH_W'(0) - sum) : sum;

   generate
      if (IS_POW2) begin : g_mask
         logic              done_ff;
         logic [IDX_W-1:0]  home_ff;

         // reduction is a mask of the low bits
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               home_ff <= mag[IDX_W-1:0];
            end
         end

         assign done = done_ff;
         assign home = home_ff;
      end else begin : g_recip
         localparam logic [IDX_W:0]    CAP_EXT = (IDX_W+1)'(CAPACITY);
         localparam logic [HASH_W-1:0] RECIP   = HASH_W'((64'd1 << HASH_W) / CAPACITY);

         logic                stage1_ff;
         logic                stage2_ff;
         logic                done_ff;
         logic [HASH_W-1:0]   mag_ff;
         logic [HASH_W-1:0]   quot_ff;
         logic [IDX_W-1:0]    home_ff;
         logic [2*HASH_W-1:0] prod;
         logic [IDX_W:0]      quot_cap;
         logic [IDX_W:0]      rem_est;

         // quotient estimate from the truncated reciprocal, low by at most one
         assign prod     = (2*HASH_W)'(mag_ff) * (2*HASH_W)'(RECIP);
         // remainder estimate stays below twice the capacity, so low bits suffice
         assign quot_cap = quot_ff[IDX_W:0] * CAP_EXT;
         assign rem_est  = mag_ff[IDX_W:0] - quot_cap;

         // three stages: capture, multiply, correct
         always_ff @(posedge clock) begin
            if (reset) begin
               stage1_ff <= 1'b0;
               stage2_ff <= 1'b0;
               done_ff   <= 1'b0;
            end else begin
               stage1_ff <= start;
               stage2_ff <= stage1_ff;
               done_ff   <= stage2_ff;
            end
            if (start) begin
               mag_ff <= mag;
            end
            quot_ff <= prod[2*HASH_W-1:HASH_W];
            home_ff <= (rem_est >= CAP_EXT) ? IDX_W'(rem_est - CAP_EXT) : rem_est[IDX_W-1:0];
         end

         assign done = done_ff;
         assign home = home_ff;
      end
   endgenerate

endmodule

// File: hdl/lpast_store.sv
// lpast_store: slot memory holding the key and size of every table entry
// one write and one read port, read data registered, no dependencies
`timescale 1ns / 1ps

module lpast_store #(
   parameter int DEPTH     = 2048,
   parameter int KEY_BITS  = 48,
   parameter int SIZE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [KEY_BITS-1:0]      rd_key,
   output logic [SIZE_BITS-1:0]     rd_size,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [KEY_BITS-1:0]      wr_key,
   input  logic [SIZE_BITS-1:0]     wr_size
);

   logic [KEY_BITS-1:0]  key_mem  [DEPTH];
   logic [SIZE_BITS-1:0] size_mem [DEPTH];
   logic [KEY_BITS-1:0]  rd_key_ff;
   logic [SIZE_BITS-1:0] rd_size_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= wr_key;
         size_mem[wr_addr] <= wr_size;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_size_ff <= size_mem[rd_addr];
      end
   end

   assign rd_key  = rd_key_ff;
   assign rd_size = rd_size_ff;

endmodule

// File: hdl/linear_probe_address_size_table_unit.sv
// Address-to-size table with linear probing over a slot memory with one
// read and one write port. After reset the block sweeps the slot memory to
// empty, one slot a cycle, and holds req_stall high meanwhile. An operation
// is then accepted, passes the home slot computation, probes slots through
// the registered memory read, and posts its response once the output
// register is free. Probes issue one read a cycle, so the probe run length
// of the key sets the rate; a miss scans all CAPACITY slots. Full, key-zero
// and undefined-command cases skip the hash and probe and go straight to
// the response. One operation is in flight at a time; a new transaction is
// taken while the previous response still waits in the output register.
// depends on lpast_pkg, lpast_hash, lpast_store
`timescale 1ns / 1ps

module linear_probe_address_size_table_unit #(
   parameter int CAPACITY  = 2048,
   parameter int KEY_BITS  = 48,
   parameter int SIZE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  lpast_pkg::cmd_type      req_command,
   input  logic [KEY_BITS-1:0]     req_key,
   input  logic [SIZE_BITS-1:0]    req_block_size,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output lpast_pkg::status_type   rsp_status,
   output lpast_pkg::found_type    rsp_found_size,
   output lpast_pkg::occ_type      rsp_occupancy
);
   import lpast_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int PCNT_W = $clog2(CAPACITY + 1);
   localparam int CNT_W  = $clog2(CAPACITY / 2 + 2);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CAPACITY - 1);
   localparam logic [PCNT_W-1:0] PROBE_ALL = PCNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0]  HALF_CAP  = CNT_W'(CAPACITY / 2);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [IDX_W-1:0]     clr_idx_ff, clr_idx_in;
   logic [IDX_W-1:0]     issue_idx_ff, issue_idx_in;
   logic [PCNT_W-1:0]    issue_cnt_ff, issue_cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]     rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0]     cmp_cnt_ff, cmp_cnt_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   status_type           status_ff, status_in;
   logic [SIZE_BITS-1:0] found_ff, found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   found_type            rsp_found_size_ff, rsp_found_size_in;
   occ_type              rsp_occupancy_ff, rsp_occupancy_in;

   logic                 hash_start;
   logic                 hash_done;
   logic [IDX_W-1:0]     hash_home;

   logic                 mem_rd_en;
   logic [KEY_BITS-1:0]  mem_rd_key;
   logic [SIZE_BITS-1:0] mem_rd_size;
   logic                 mem_wr_en;
   logic [IDX_W-1:0]     mem_wr_addr;
   logic [KEY_BITS-1:0]  mem_wr_key;
   logic [SIZE_BITS-1:0] mem_wr_size;

   logic                 slot_hit;
   logic                 slot_empty;
   logic                 last_probe;
   logic [63:0]          found_ext;
   logic [31:0]          count_ext;

   // home slot unit
   lpast_hash #(
      .CAPACITY (CAPACITY)
   ) u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .key_low (req_key[HASH_W-1:0]),
      .done    (hash_done),
      .home    (hash_home)
   );

   // slot memory
   lpast_store #(
      .DEPTH     (CAPACITY),
      .KEY_BITS  (KEY_BITS),
      .SIZE_BITS (SIZE_BITS)
   ) u_store (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (issue_idx_ff),
      .rd_key  (mem_rd_key),
      .rd_size (mem_rd_size),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_key  (mem_wr_key),
      .wr_size (mem_wr_size)
   );

   // slot compare on the returning read data
   assign slot_hit   = (mem_rd_key == key_ff);
   assign slot_empty = (mem_rd_key == '0);
   assign last_probe = (cmp_cnt_ff == LAST_IDX);

   // response field extension to the fixed port widths
   assign found_ext = 64'(found_ff);
   assign count_ext = 32'(count_ff);

   // next state and datapath
   always_comb begin
      state_in          = state_ff;
      cmd_in            = cmd_ff;
      key_in            = key_ff;
      size_in           = size_ff;
      clr_idx_in        = clr_idx_ff;
      issue_idx_in      = issue_idx_ff;
      issue_cnt_in      = issue_cnt_ff;
      rd_vld_in         = rd_vld_ff;
      rd_addr_in        = rd_addr_ff;
      cmp_cnt_in        = cmp_cnt_ff;
      count_in          = count_ff;
      status_in         = status_ff;
      found_in          = found_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_found_size_in = rsp_found_size_ff;
      rsp_occupancy_in  = rsp_occupancy_ff;
      hash_start        = 1'b0;
      mem_rd_en         = 1'b0;
      mem_wr_en         = 1'b0;
      mem_wr_addr       = rd_addr_ff;
      mem_wr_key        = '0;
      mem_wr_size       = '0;

      // response taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_idx_ff;
            clr_idx_in  = clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               key_in   = req_key;
               size_in  = req_block_size;
               found_in = '0;
               if (req_command == CMD_INSERT && count_ff > HALF_CAP) begin
                  status_in = STATUS_FULL;
                  state_in  = S_FINISH;
               end else if (req_key == '0 || req_command == CMD_UNDEF) begin
                  status_in = STATUS_MISS;
                  state_in  = S_FINISH;
               end else begin
                  hash_start = 1'b1;
                  state_in   = S_HASH;
               end
            end
         end

         S_HASH: begin
            if (hash_done) begin
               issue_idx_in = hash_home;
               issue_cnt_in = '0;
               rd_vld_in    = 1'b0;
               cmp_cnt_in   = '0;
               state_in     = S_PROBE;
            end
         end

         S_PROBE: begin
            // issue one slot read a cycle, wrapping round the table
            if (issue_cnt_ff != PROBE_ALL) begin
               mem_rd_en    = 1'b1;
               rd_vld_in    = 1'b1;
               rd_addr_in   = issue_idx_ff;
               issue_idx_in = (issue_idx_ff == LAST_IDX) ? '0 : issue_idx_ff + IDX_W'(1);
               issue_cnt_in = issue_cnt_ff + PCNT_W'(1);
            end else begin
               rd_vld_in = 1'b0;
            end
            // resolve on the slot read last cycle
            if (rd_vld_ff) begin
               cmp_cnt_in = cmp_cnt_ff + IDX_W'(1);
               if (cmd_ff == CMD_INSERT) begin
                  if (slot_empty) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_key  = key_ff;
                     mem_wr_size = size_ff;
                     count_in    = count_ff + CNT_W'(1);
                     status_in   = STATUS_OK;
                     state_in    = S_FINISH;
                  end else if (slot_hit) begin
                     status_in = STATUS_DUP;
                     state_in  = S_FINISH;
                  end else if (last_probe) begin
                     status_in = STATUS_FULL;
                     state_in  = S_FINISH;
                  end
               end else begin
                  if (slot_hit) begin
                     status_in = STATUS_OK;
                     state_in  = S_FINISH;
                     if (cmd_ff == CMD_REMOVE) begin
                        mem_wr_en = 1'b1;
                        if (count_ff != '0) begin
                           count_in = count_ff - CNT_W'(1);
                        end
                     end else begin
                        found_in = mem_rd_size;
                     end
                  end else if (last_probe) begin
                     status_in = STATUS_MISS;
                     state_in  = S_FINISH;
                  end
               end
            end
         end

         S_FINISH: begin
            // post the response once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = status_ff;
               rsp_found_size_in = found_ext[FOUND_W-1:0];
               rsp_occupancy_in  = count_ext[OCC_W-1:0];
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
      end
      cmd_ff            <= cmd_in;
      key_ff            <= key_in;
      size_ff           <= size_in;
      issue_idx_ff      <= issue_idx_in;
      issue_cnt_ff      <= issue_cnt_in;
      rd_addr_ff        <= rd_addr_in;
      cmp_cnt_ff        <= cmp_cnt_in;
      status_ff         <= status_in;
      found_ff          <= found_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_found_size_ff <= rsp_found_size_in;
      rsp_occupancy_ff  <= rsp_occupancy_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found_size = rsp_found_size_ff;
   assign rsp_occupancy  = rsp_occupancy_ff;

endmodule

// File: verif/linear_probe_address_size_table_unit_test.sv
// linear_probe_address_size_table_unit_test: self-checking bench for the address/size table
// predicts every response from its own copy of the slot store; drives both channels with idling
// depends on lpast_pkg and linear_probe_address_size_table_unit
`timescale 1ns / 1ps

module linear_probe_address_size_table_unit_test;
   import lpast_pkg::*;

   localparam int unsigned SLOTS          = 2048;
   localparam int          KEY_W          = 48;
   localparam int          SIZE_W         = 32;
   // a miss or the clearing sweep after reset each walk all SLOTS slots
   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned TAIL_CYCLES    = 40;

   // table predictor and response checker
   class table_scoreboard #(int unsigned SLOTS = 2048, int KEY_W = 48, int SIZE_W = 32);
      typedef struct {
         status_type status;
         found_type  found;
         occ_type    occupancy;
      } reply_type;

      bit [KEY_W-1:0]  key_at  [SLOTS];
      bit [SIZE_W-1:0] size_at [SLOTS];
      int unsigned     live_count;
      reply_type       awaited [$];
      int unsigned     replies_seen;
      int unsigned     mismatches;

      function int unsigned pending();
         return awaited.size();
      endfunction

      function int unsigned occupancy();
         return live_count;
      endfunction

      // signed low word plus offset, magnitude, then modulo the slot count
      function int unsigned home_slot(bit [KEY_W-1:0] key);
         bit [HASH_W-1:0] sum;
         sum = key[HASH_W-1:0] + HASH_OFFSET;
         if (sum[HASH_W-1]) sum = '0 - sum;
         return sum % SLOTS;
      endfunction

      // apply one accepted transaction to the store and queue its response
      function status_type note_request(cmd_type cmd, bit [KEY_W-1:0] key,
                                        bit [SIZE_W-1:0] bsize);
         reply_type   r;
         int unsigned idx;
         r.status = STATUS_MISS;
         r.found  = '0;
         idx      = home_slot(key);
         if (cmd == CMD_INSERT) begin
            // full wins over duplicate, checked before probing
            if (live_count > SLOTS / 2) begin
               r.status = STATUS_FULL;
            end else if (key != '0) begin
               r.status = STATUS_FULL;
               for (int n = 0; n < SLOTS; n++) begin
                  if (key_at[idx] == '0) begin
                     key_at[idx]  = key;
                     size_at[idx] = bsize;
                     live_count++;
                     r.status = STATUS_OK;
                     break;
                  end
                  if (key_at[idx] == key) begin
                     r.status = STATUS_DUP;
                     break;
                  end
                  idx = (idx + 1) % SLOTS;
               end
            end
         end else if ((cmd == CMD_REMOVE || cmd == CMD_SEARCH) && key != '0) begin
            // lookups walk the whole table, holes included
            for (int n = 0; n < SLOTS; n++) begin
               if (key_at[idx] == key) begin
                  r.status = STATUS_OK;
                  if (cmd == CMD_REMOVE) begin
                     key_at[idx]  = '0;
                     size_at[idx] = '0;
                     if (live_count > 0) live_count--;
                  end else begin
                     r.found = size_at[idx];
                  end
                  break;
               end
               idx = (idx + 1) % SLOTS;
            end
         end
         r.occupancy = occ_type'(live_count);
         awaited.push_back(r);
         return r.status;
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         mismatches++;
      endtask

      task check_response(status_type status, found_type found, occ_type occ);
         reply_type want;
         replies_seen++;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with nothing pending", replies_seen));
         end else begin
            want = awaited.pop_front();
            if (status !== want.status)
               report_mismatch($sformatf("response %0d status got %0d want %0d",
                                         replies_seen, status, want.status));
            if (found !== want.found)
               report_mismatch($sformatf("response %0d found_size got %h want %h",
                                         replies_seen, found, want.found));
            if (occ !== want.occupancy)
               report_mismatch($sformatf("response %0d occupancy got %0d want %0d",
                                         replies_seen, occ, want.occupancy));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   cmd_type               req_command;
   logic [KEY_W-1:0]      req_key;
   logic [SIZE_W-1:0]     req_block_size;
   logic                  rsp_valid;
   logic                  rsp_stall;
   status_type            rsp_status;
   found_type             rsp_found_size;
   occ_type               rsp_occupancy;

   table_scoreboard #(SLOTS, KEY_W, SIZE_W) board;
   logic [KEY_W-1:0]      live_keys [$];
   bit                    sender_idles   = 1'b1;
   bit                    receiver_idles = 1'b1;
   int unsigned           items_sent     = 0;

   linear_probe_address_size_table_unit #(
      .CAPACITY  (SLOTS),
      .KEY_BITS  (KEY_W),
      .SIZE_BITS (SIZE_W)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_key        (req_key),
      .req_block_size (req_block_size),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_found_size (rsp_found_size),
      .rsp_occupancy  (rsp_occupancy)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // new random key, now and then sharing a low word to crowd one home slot
   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] key;
      key = KEY_W'({$urandom, $urandom});
      case ($urandom_range(0, 39))
         0: key[31:0] = 32'h7FFF_FE8E;   // hash sum lands on the most negative value
         1: key[31:0] = 32'h0000_068D;   // home is the last slot, probes wrap
         2: key[31:0] = 32'hFFFF_FE8E;   // hash sum wraps to zero
         3: key[31:0] = 32'h0000_0000;
         default: ;
      endcase
      if (key == '0) key = KEY_W'(1);
      return key;
   endfunction

   // drive one request transaction and wait for its acceptance
   task automatic send_request(cmd_type cmd, logic [KEY_W-1:0] key,
                               logic [SIZE_W-1:0] bsize);
      int unsigned gap;
      status_type  outcome;
      bit          gone;
      gap = sender_idles ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_key        <= key;
      req_block_size <= bsize;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      outcome = board.note_request(cmd, key, bsize);
      // track which keys are live for the stimulus
      if (cmd == CMD_INSERT && outcome == STATUS_OK) begin
         live_keys.push_back(key);
      end else if (cmd == CMD_REMOVE && outcome == STATUS_OK) begin
         gone = 1'b0;
         for (int i = 0; i < live_keys.size() && !gone; i++) begin
            if (live_keys[i] == key) begin
               live_keys.delete(i);
               gone = 1'b1;
            end
         end
      end
      items_sent++;
      // change idling habits every so often, leaving some stretches without gaps
      if (items_sent % 64 == 0) begin
         sender_idles   = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
      end
   endtask

   // one random transaction; the percentages left over go to key zero and undefined commands
   task automatic random_item(int unsigned p_new, int unsigned p_dup, int unsigned p_find,
                              int unsigned p_drop, int unsigned p_miss);
      int unsigned      roll;
      logic [KEY_W-1:0] known;
      roll  = $urandom_range(0, 99);
      known = '0;
      if (live_keys.size() != 0)
         known = live_keys[$urandom_range(0, live_keys.size() - 1)];
      else if (roll >= p_new && roll < p_new + p_dup + p_find + p_drop)
         roll = 0;
      if (roll < p_new)
         send_request(CMD_INSERT, fresh_key(), $urandom);
      else if (roll < p_new + p_dup)
         send_request(CMD_INSERT, known, $urandom);
      else if (roll < p_new + p_dup + p_find)
         send_request(CMD_SEARCH, known, $urandom);
      else if (roll < p_new + p_dup + p_find + p_drop)
         send_request(CMD_REMOVE, known, $urandom);
      else if (roll < p_new + p_dup + p_find + p_drop + p_miss)
         send_request($urandom_range(0, 1) ? CMD_SEARCH : CMD_REMOVE, fresh_key(), $urandom);
      else if ($urandom_range(0, 1))
         send_request(cmd_type'($urandom_range(0, 2)), '0, $urandom);
      else
         send_request(CMD_UNDEF, known, $urandom);
   endtask

   // hold the sender off until every pending response has come back
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // response sink with random stall after each transaction
   initial begin : reply_sink
      int unsigned hold;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            board.check_response(rsp_status, rsp_found_size, rsp_occupancy);
            hold = receiver_idles ? $urandom_range(0, 3) : 0;
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet = 0;
         else
            quiet++;
      end
      $display("linear_probe_address_size_table_unit_test: FAIL");
      $finish;
   end

   // stimulus
   initial begin
      board = new();
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_command    <= CMD_INSERT;
      req_key        <= '0;
      req_block_size <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, key zero, undefined command
      send_request(CMD_SEARCH, 48'h0000_0000_0001, 32'h0);
      send_request(CMD_INSERT, 48'h0, 32'hFFFF_FFFF);
      send_request(CMD_REMOVE, 48'h0, 32'h0);
      send_request(CMD_SEARCH, 48'h0, 32'h0);
      send_request(CMD_UNDEF, 48'h0000_0000_0001, 32'h1234_5678);
      // largest key and size, duplicate, hit
      send_request(CMD_INSERT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_INSERT, 48'hFFFF_FFFF_FFFF, 32'h0);
      send_request(CMD_SEARCH, 48'hFFFF_FFFF_FFFF, 32'h0);
      // most negative hash sum takes slot zero
      send_request(CMD_INSERT, 48'h0000_7FFF_FE8E, 32'h8000_0001);
      send_request(CMD_SEARCH, 48'h0000_7FFF_FE8E, 32'h0);
      // collisions on the last slot wrap past slot zero
      send_request(CMD_INSERT, 48'h0000_0000_068D, 32'h1);
      send_request(CMD_INSERT, 48'h0001_0000_068D, 32'h2);
      send_request(CMD_INSERT, 48'hFFFF_0000_068D, 32'h3);
      send_request(CMD_SEARCH, 48'hFFFF_0000_068D, 32'h0);
      // removal leaves a hole that lookups walk across
      send_request(CMD_REMOVE, 48'h0000_0000_068D, 32'h0);
      send_request(CMD_SEARCH, 48'hFFFF_0000_068D, 32'h0);
      send_request(CMD_SEARCH, 48'h0000_0000_068D, 32'h0);
      send_request(CMD_REMOVE, 48'h0000_0000_068D, 32'h0);
      send_request(CMD_UNDEF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      // hash sum wrapping to zero, zero size stored
      send_request(CMD_INSERT, 48'h0000_FFFF_FE8E, 32'h0);
      send_request(CMD_SEARCH, 48'h0000_FFFF_FE8E, 32'hFFFF_FFFF);
      send_request(CMD_REMOVE, 48'hFFFF_FFFF_FFFF, 32'h0);
      send_request(CMD_INSERT, 48'h8000_0000_0000, 32'h5A5A_5A5A);
      send_request(CMD_SEARCH, 48'h8000_0000_0000, 32'h0);
      live_keys.push_back(48'h0001_0000_068D);
      live_keys.delete(live_keys.size() - 1);
      wait_for_replies();

      // mixed traffic at light load
      repeat (500) random_item(40, 8, 20, 15, 7);
      wait_for_replies();

      // fill until the table refuses inserts
      while (board.occupancy() <= SLOTS / 2) random_item(90, 0, 10, 0, 0);
      // hover at the full mark: full beats duplicate, removals reopen space
      repeat (80) random_item(35, 20, 20, 20, 0);
      // drain
      repeat (250) random_item(10, 5, 25, 50, 6);

      wait_for_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("linear_probe_address_size_table_unit_test: PASS");
      else
         $display("linear_probe_address_size_table_unit_test: FAIL");
      $finish;
   end

endmodule
